FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_SAME(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/akm_pkg.sv
package akm_pkg;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       alarm_fire;
      logic [4:0] entry_total;
   } rsp_type;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_CHECK  = 2'd2;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_DUP     = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_MISSING = 2'd3;

   localparam int STEP_W = 5;
   localparam int COND_W = 4;

   // Microprogram step addresses.
   localparam logic [STEP_W-1:0] S_IDLE     = 5'd0;
   localparam logic [STEP_W-1:0] S_SKIP     = 5'd1;
   localparam logic [STEP_W-1:0] S_TEST     = 5'd2;
   localparam logic [STEP_W-1:0] S_CMP      = 5'd3;
   localparam logic [STEP_W-1:0] S_HIT      = 5'd4;
   localparam logic [STEP_W-1:0] S_HIT_DEL  = 5'd5;
   localparam logic [STEP_W-1:0] S_FIRE     = 5'd6;
   localparam logic [STEP_W-1:0] S_DUP      = 5'd7;
   localparam logic [STEP_W-1:0] S_SH_TEST  = 5'd8;
   localparam logic [STEP_W-1:0] S_SH_WR    = 5'd9;
   localparam logic [STEP_W-1:0] S_SH_DONE  = 5'd10;
   localparam logic [STEP_W-1:0] S_MISS     = 5'd11;
   localparam logic [STEP_W-1:0] S_MISS_DEL = 5'd12;
   localparam logic [STEP_W-1:0] S_MISS_CHK = 5'd13;
   localparam logic [STEP_W-1:0] S_INS      = 5'd14;
   localparam logic [STEP_W-1:0] S_INS_WR   = 5'd15;
   localparam logic [STEP_W-1:0] S_FULL     = 5'd16;
   localparam logic [STEP_W-1:0] S_NOTF     = 5'd17;
   localparam logic [STEP_W-1:0] S_EMIT     = 5'd18;

   // Jump conditions.
   localparam logic [COND_W-1:0] C_NEVER     = 4'd0;
   localparam logic [COND_W-1:0] C_ALWAYS    = 4'd1;
   localparam logic [COND_W-1:0] C_NOT_START = 4'd2;
   localparam logic [COND_W-1:0] C_SKIP      = 4'd3;
   localparam logic [COND_W-1:0] C_END       = 4'd4;
   localparam logic [COND_W-1:0] C_NOMATCH   = 4'd5;
   localparam logic [COND_W-1:0] C_IS_INSERT = 4'd6;
   localparam logic [COND_W-1:0] C_IS_DELETE = 4'd7;
   localparam logic [COND_W-1:0] C_SHIFT_END = 4'd8;
   localparam logic [COND_W-1:0] C_FULL      = 4'd9;

   typedef struct packed {
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] target;
      logic              ld_req;
      logic              inc_idx;
      logic              rd_next;
      logic              wr_en;
      logic              wsel_key;
      logic              cnt_inc;
      logic              cnt_dec;
      logic              ld_status;
      logic [1:0]        status;
      logic              set_fire;
      logic              emit;
   } ucode_type;

   typedef struct packed {
      logic       ld_req;
      logic       inc_idx;
      logic       rd_next;
      logic       wr_en;
      logic       wsel_key;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       ld_status;
      logic [1:0] status;
      logic       set_fire;
   } ctl_type;

   typedef struct packed {
      logic is_end;
      logic nomatch;
      logic is_insert;
      logic is_delete;
      logic skip;
      logic shift_end;
      logic full;
   } flags_type;

   // The control store. A taken jump goes to target, otherwise to the next step.
   // The index increment fires only on a taken jump.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '0;
      case (step)
         S_IDLE: begin
            w.cond   = C_NOT_START;
            w.target = S_IDLE;
            w.ld_req = 1'b1;
         end
         S_SKIP: begin
            w.cond   = C_SKIP;
            w.target = S_EMIT;
         end
         S_TEST: begin
            w.cond   = C_END;
            w.target = S_MISS;
         end
         S_CMP: begin
            w.cond    = C_NOMATCH;
            w.target  = S_TEST;
            w.inc_idx = 1'b1;
         end
         S_HIT: begin
            w.cond   = C_IS_INSERT;
            w.target = S_DUP;
         end
         S_HIT_DEL: begin
            w.cond   = C_IS_DELETE;
            w.target = S_SH_TEST;
         end
         S_FIRE: begin
            w.cond     = C_ALWAYS;
            w.target   = S_EMIT;
            w.set_fire = 1'b1;
         end
         S_DUP: begin
            w.cond      = C_ALWAYS;
            w.target    = S_EMIT;
            w.ld_status = 1'b1;
            w.status    = ST_DUP;
         end
         S_SH_TEST: begin
            w.cond    = C_SHIFT_END;
            w.target  = S_SH_DONE;
            w.rd_next = 1'b1;
         end
         S_SH_WR: begin
            w.cond    = C_ALWAYS;
            w.target  = S_SH_TEST;
            w.wr_en   = 1'b1;
            w.inc_idx = 1'b1;
         end
         S_SH_DONE: begin
            w.cond    = C_ALWAYS;
            w.target  = S_EMIT;
            w.cnt_dec = 1'b1;
         end
         S_MISS: begin
            w.cond   = C_IS_INSERT;
            w.target = S_INS;
         end
         S_MISS_DEL: begin
            w.cond   = C_IS_DELETE;
            w.target = S_NOTF;
         end
         S_MISS_CHK: begin
            w.cond   = C_ALWAYS;
            w.target = S_EMIT;
         end
         S_INS: begin
            w.cond   = C_FULL;
            w.target = S_FULL;
         end
         S_INS_WR: begin
            w.cond     = C_ALWAYS;
            w.target   = S_EMIT;
            w.wr_en    = 1'b1;
            w.wsel_key = 1'b1;
            w.cnt_inc  = 1'b1;
         end
         S_FULL: begin
            w.cond      = C_ALWAYS;
            w.target    = S_EMIT;
            w.ld_status = 1'b1;
            w.status    = ST_FULL;
         end
         S_NOTF: begin
            w.cond      = C_ALWAYS;
            w.target    = S_EMIT;
            w.ld_status = 1'b1;
            w.status    = ST_MISSING;
         end
         S_EMIT: begin
            w.cond   = C_ALWAYS;
            w.target = S_IDLE;
            w.emit   = 1'b1;
         end
         default: begin
            w.cond   = C_ALWAYS;
            w.target = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/core/akm_ram.sv
module akm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/akm_seq.sv
module akm_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  akm_pkg::flags_type  flags,
   output akm_pkg::ctl_type    ctl,
   output logic                busy,
   output logic                emit
);

   logic [akm_pkg::STEP_W-1:0] pc_ff;
   logic [akm_pkg::STEP_W-1:0] pc_in;
   akm_pkg::ucode_type         word;
   logic                       taken;

   assign word = akm_pkg::ucode_rom(pc_ff);

   always_comb begin
      case (word.cond)
         akm_pkg::C_NEVER:     taken = 1'b0;
         akm_pkg::C_ALWAYS:    taken = 1'b1;
         akm_pkg::C_NOT_START: taken = !start;
         akm_pkg::C_SKIP:      taken = flags.skip;
         akm_pkg::C_END:       taken = flags.is_end;
         akm_pkg::C_NOMATCH:   taken = flags.nomatch;
         akm_pkg::C_IS_INSERT: taken = flags.is_insert;
         akm_pkg::C_IS_DELETE: taken = flags.is_delete;
         akm_pkg::C_SHIFT_END: taken = flags.shift_end;
         akm_pkg::C_FULL:      taken = flags.full;
         default:              taken = 1'b0;
      endcase
   end

   assign pc_in = taken ? word.target : pc_ff + akm_pkg::STEP_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= akm_pkg::S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   always_comb begin
      ctl.ld_req    = word.ld_req & start;
      ctl.inc_idx   = word.inc_idx & taken;
      ctl.rd_next   = word.rd_next;
      ctl.wr_en     = word.wr_en;
      ctl.wsel_key  = word.wsel_key;
      ctl.cnt_inc   = word.cnt_inc;
      ctl.cnt_dec   = word.cnt_dec;
      ctl.ld_status = word.ld_status;
      ctl.status    = word.status;
      ctl.set_fire  = word.set_fire;
   end

   assign busy = (pc_ff != akm_pkg::S_IDLE);
   assign emit = word.emit;

endmodule

FILE: rtl/core/akm_dpath.sv
module akm_dpath #(
   parameter int MAX_KEYS = 16,
   parameter int KEY_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  akm_pkg::ctl_type   ctl,
   input  akm_pkg::req_type   req_data,
   output akm_pkg::flags_type flags,
   output akm_pkg::rsp_type   rsp_data
);

   localparam int AW    = $clog2(MAX_KEYS);
   localparam int CNT_W = $clog2(MAX_KEYS + 1);
   localparam int EXT_W = CNT_W + 5;

   logic [1:0]          op_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [CNT_W-1:0]    idx_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [1:0]          status_ff;
   logic                fire_ff;
   logic                fired_ff;

   logic [CNT_W-1:0]    idx_next;
   logic [AW-1:0]       rd_addr;
   logic [KEY_BITS-1:0] rd_data;
   logic [KEY_BITS-1:0] wr_data;
   logic [EXT_W-1:0]    cnt_ext;
   logic                op_valid;

   assign idx_next = idx_ff + CNT_W'(1);
   assign rd_addr  = ctl.rd_next ? idx_next[AW-1:0] : idx_ff[AW-1:0];
   assign wr_data  = ctl.wsel_key ? key_ff : rd_data;

   akm_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (MAX_KEYS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (idx_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (ctl.ld_req) begin
         op_ff  <= req_data.opcode;
         key_ff <= KEY_BITS'(req_data.key);
         idx_ff <= '0;
      end else if (ctl.inc_idx) begin
         idx_ff <= idx_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         fired_ff  <= 1'b0;
         fire_ff   <= 1'b0;
         status_ff <= akm_pkg::ST_DONE;
      end else begin
         if (ctl.cnt_inc) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else if (ctl.cnt_dec) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
         if (ctl.ld_req) begin
            fire_ff   <= 1'b0;
            status_ff <= akm_pkg::ST_DONE;
         end else begin
            if (ctl.set_fire) begin
               fire_ff  <= 1'b1;
               fired_ff <= 1'b1;
            end
            if (ctl.ld_status) begin
               status_ff <= ctl.status;
            end
         end
      end
   end

   // Opcode three does nothing; a check after the latch has fired skips the scan.
   assign op_valid = (op_ff == akm_pkg::OP_INSERT) || (op_ff == akm_pkg::OP_DELETE) ||
                     (op_ff == akm_pkg::OP_CHECK);

   always_comb begin
      flags.is_end    = (idx_ff == cnt_ff);
      flags.nomatch   = (rd_data != key_ff);
      flags.is_insert = (op_ff == akm_pkg::OP_INSERT);
      flags.is_delete = (op_ff == akm_pkg::OP_DELETE);
      flags.skip      = !op_valid || ((op_ff == akm_pkg::OP_CHECK) && fired_ff);
      flags.shift_end = ({1'b0, idx_ff} + (CNT_W + 1)'(1)) >= {1'b0, cnt_ff};
      flags.full      = (cnt_ff == CNT_W'(MAX_KEYS));
   end

   assign cnt_ext = EXT_W'(cnt_ff);

   always_comb begin
      rsp_data.status      = status_ff;
      rsp_data.alarm_fire  = fire_ff;
      rsp_data.entry_total = cnt_ext[4:0];
   end

endmodule

FILE: rtl/core/alarm_key_set_match_core.sv
// Channel        Ports                        Direction  Handshake
// request        start, busy, req_data        in         taken when start && !busy
// response       rsp_valid, rsp_data          out        one-cycle strobe, no back-pressure
//
// The unused opcode, or a check once the alarm has fired, skips the scan of the key
// store; every other transaction keeps busy high while it scans the store, a RAM with
// a registered read, key by key, and a delete that finds its key then moves each later
// key down by one place, then lowers the count.
// Reset is synchronous and active high; it empties the set and clears the alarm latch.
// The receiver cannot stall: each response is shown for exactly one cycle, and busy
// falls in the cycle after it, when the next request can be taken.

`include "assert_macros.svh"

module alarm_key_set_match_core #(
   parameter int MAX_KEYS = 16,
   parameter int KEY_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  akm_pkg::req_type req_data,
   output logic             rsp_valid,
   output akm_pkg::rsp_type rsp_data
);

   // The sequencer walks a short microprogram held in a constant table. Each step
   // raises control lines into the datapath and may jump on a condition that the
   // datapath reports back (end of the held keys, key mismatch, opcode, full set).
   akm_pkg::ctl_type   ctl;
   akm_pkg::flags_type flags;

   akm_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .ctl   (ctl),
      .busy  (busy),
      .emit  (rsp_valid)
   );

   // The datapath holds the key store, the entry count, the scan index and the
   // latch that remembers the first alarm since reset.
   akm_dpath #(
      .MAX_KEYS (MAX_KEYS),
      .KEY_BITS (KEY_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req_data (req_data),
      .flags    (flags),
      .rsp_data (rsp_data)
   );

   // A response only ever appears while a transaction is in flight.
   `ASSERT_SAME(a_rsp_in_txn, clock, reset, rsp_valid, busy)
   // An accepted request always makes the block busy in the next cycle.
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // After its response the block is free again.
   `ASSERT_NEXT(a_rsp_frees, clock, reset, rsp_valid, !busy)

endmodule

FILE: tb/alarm_key_set_match_core_tb.sv
`timescale 1ns / 1ps

module alarm_key_set_match_core_tb;

   localparam int SET_DEPTH = 16;
   localparam int KEY_W = 32;
   // The block decodes nothing for the fourth opcode value; it must act as a no-op.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1625;
   localparam int POOL_SIZE = 24;
   // Longest span between two accepted requests: a scan of every held key, the fixed
   // steps and the idle step after the response.
   localparam int WORST_CYCLES = 2 * SET_DEPTH + 7;
   // The slowest correct run, about 1650 worst-case requests each with the longest gap,
   // is roughly 1.3 ms, so this limit leaves more than four times that.
   localparam int TIMEOUT_NS = 8_000_000;

   // The scoreboard keeps its own copy of the key set and of the alarm latch. Each
   // accepted request is applied to that copy at once, and the response it ought to
   // produce is queued until the block shows its response.
   class key_set_scoreboard_type;
      logic [KEY_W-1:0] held_keys [SET_DEPTH];
      int unsigned      held_total;
      bit               alarm_latched;
      akm_pkg::rsp_type expected_rsps [$];
      int unsigned      mismatches;
      int unsigned      op_seen [4];
      int unsigned      status_seen [4];
      int unsigned      fires;
      int unsigned      empties;

      function new();
         held_total    = 0;
         alarm_latched = 1'b0;
         mismatches    = 0;
         fires         = 0;
         empties       = 0;
         foreach (op_seen[i]) op_seen[i] = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function int find_key(logic [KEY_W-1:0] k);
         for (int i = 0; i < held_total; i++) begin
            if (held_keys[i] === k) return i;
         end
         return -1;
      endfunction

      // Applies one request to the held set and returns the response it causes.
      function akm_pkg::rsp_type apply_op(akm_pkg::req_type r);
         akm_pkg::rsp_type e;
         int               hit_at;
         e      = '0;
         e.status = akm_pkg::ST_DONE;
         hit_at = find_key(r.key);
         case (r.opcode)
            akm_pkg::OP_INSERT: begin
               if (hit_at >= 0) begin
                  e.status = akm_pkg::ST_DUP;
               end else if (held_total >= SET_DEPTH) begin
                  e.status = akm_pkg::ST_FULL;
               end else begin
                  held_keys[held_total] = r.key;
                  held_total++;
               end
            end
            akm_pkg::OP_DELETE: begin
               if (hit_at < 0) begin
                  e.status = akm_pkg::ST_MISSING;
               end else begin
                  for (int i = hit_at; i + 1 < held_total; i++)
                     held_keys[i] = held_keys[i + 1];
                  held_total--;
               end
            end
            akm_pkg::OP_CHECK: begin
               if (!alarm_latched && hit_at >= 0) begin
                  alarm_latched = 1'b1;
                  e.alarm_fire  = 1'b1;
               end
            end
            default: begin
            end
         endcase
         e.entry_total = held_total[4:0];
         return e;
      endfunction

      function void note_request(akm_pkg::req_type r);
         akm_pkg::rsp_type e;
         e = apply_op(r);
         expected_rsps.push_back(e);
         op_seen[r.opcode]++;
         status_seen[e.status]++;
         if (e.alarm_fire) fires++;
         if (r.opcode == akm_pkg::OP_DELETE && e.status == akm_pkg::ST_DONE &&
             held_total == 0) empties++;
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_response(akm_pkg::rsp_type got);
         akm_pkg::rsp_type want;
         if (expected_rsps.size() == 0) begin
            report_mismatch($sformatf("response with nothing outstanding (status %0d)",
                                      got.status));
            return;
         end
         want = expected_rsps.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.alarm_fire !== want.alarm_fire)
            report_mismatch($sformatf("alarm_fire %0b, expected %0b",
                                      got.alarm_fire, want.alarm_fire));
         if (got.entry_total !== want.entry_total)
            report_mismatch($sformatf("entry_total %0d, expected %0d",
                                      got.entry_total, want.entry_total));
      endtask

      function int pending();
         return expected_rsps.size();
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   akm_pkg::req_type req_data = '0;
   logic             rsp_valid;
   akm_pkg::rsp_type rsp_data;

   key_set_scoreboard_type board;
   logic [KEY_W-1:0]       key_pool [POOL_SIZE];
   int unsigned            settle_cycles;

   alarm_key_set_match_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // Responses cannot be held off, so every strobe seen at a rising edge is a
   // completed transaction and goes straight to the scoreboard.
   always @(posedge clock) begin
      if (reset == 1'b0 && rsp_valid === 1'b1) board.check_response(rsp_data);
   end

   // Most gaps are short, a few are long. In a quiet stretch requests follow one
   // another back to back.
   function automatic int unsigned pick_gap(bit quiet);
      int unsigned roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Keys are mostly drawn from a small pool so that inserts meet duplicates, deletes
   // find their key and the set fills up; the rest are fully random words.
   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom();
   endfunction

   // Refreshes the pool's upper half, or all if whole; the lower half keeps the
   // extremes and a few stable keys so held keys can still be found and removed.
   function automatic void refresh_pool(bit whole);
      for (int i = 0; i < POOL_SIZE; i++) begin
         if (whole || i >= POOL_SIZE / 2) key_pool[i] = $urandom();
      end
      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = 32'd1 << $urandom_range(0, KEY_W - 1);
   endfunction

   // Offers one request at a falling edge and holds it until a rising edge finds
   // busy low, which is when the transaction is taken.
   task automatic send_request(input logic [1:0] op, input logic [KEY_W-1:0] k,
                               input int unsigned gap);
      akm_pkg::req_type r;
      r.opcode = op;
      r.key    = k;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      board.note_request(r);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Withdraws the request line and waits until every outstanding response is in.
   task automatic drain_responses();
      @(negedge clock);
      start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Chooses the opcode for a random request. The run cycles through a filling
   // phase, a draining phase and an even mix, so that the set is driven to full
   // and back to empty many times over.
   function automatic logic [1:0] pick_op(int unsigned n);
      int unsigned roll;
      int unsigned insert_share;
      int unsigned delete_share;
      roll = $urandom_range(0, 99);
      case ((n / 120) % 3)
         0: begin
            insert_share = 65;
            delete_share = 15;
         end
         1: begin
            insert_share = 15;
            delete_share = 65;
         end
         default: begin
            insert_share = 40;
            delete_share = 40;
         end
      endcase
      if (roll < insert_share) return akm_pkg::OP_INSERT;
      if (roll < insert_share + delete_share) return akm_pkg::OP_DELETE;
      if (roll < 95) return akm_pkg::OP_CHECK;
      return OP_UNUSED;
   endfunction

   initial begin
      board = new();
      refresh_pool(1'b1);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Checks and deletes on an empty set, the unused opcode,
      // a duplicate insert, then filling the set with the all-ones key and one-hot
      // keys so that every key bit is seen at both values.
      send_request(akm_pkg::OP_CHECK, 32'd5, pick_gap(1'b0));
      send_request(akm_pkg::OP_DELETE, 32'd5, pick_gap(1'b0));
      send_request(OP_UNUSED, 32'hA5A5_5A5A, pick_gap(1'b0));
      send_request(akm_pkg::OP_INSERT, '0, pick_gap(1'b0));
      send_request(akm_pkg::OP_INSERT, '0, pick_gap(1'b0));
      send_request(akm_pkg::OP_INSERT, '1, pick_gap(1'b0));
      for (int i = 0; i < SET_DEPTH - 2; i++)
         send_request(akm_pkg::OP_INSERT, 32'd1 << i, pick_gap(1'b0));
      // The set is now full: a new key must be refused, whereas a key already held
      // must be reported as a duplicate even though the set is full.
      send_request(akm_pkg::OP_INSERT, 32'h8000_0000, pick_gap(1'b0));
      send_request(akm_pkg::OP_INSERT, '1, pick_gap(1'b0));
      // Removal from the middle, the front and the back of the set.
      send_request(akm_pkg::OP_DELETE, 32'd1 << 6, pick_gap(1'b0));
      send_request(akm_pkg::OP_DELETE, '0, pick_gap(1'b0));
      send_request(akm_pkg::OP_DELETE, 32'd1 << 13, pick_gap(1'b0));
      // A check that misses, the first check that hits (the alarm fires and
      // latches) and a second hit, which must now report nothing.
      send_request(akm_pkg::OP_CHECK, 32'h1234_5678, pick_gap(1'b0));
      send_request(akm_pkg::OP_CHECK, 32'd1 << 3, pick_gap(1'b0));
      send_request(akm_pkg::OP_CHECK, 32'd1 << 3, pick_gap(1'b0));
      drain_responses();

      // Random part.
      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 300 == 299) refresh_pool(1'b0);
         send_request(pick_op(n), pick_key(), pick_gap((n / 200) % 4 == 3));
         if (n == RANDOM_ITEMS / 2 || $urandom_range(0, 99) == 0) drain_responses();
      end

      // Let the last transactions complete, within a bound, then allow for one more
      // worst-case transaction in case the block produces anything stray.
      @(negedge clock);
      start <= 1'b0;
      settle_cycles = 0;
      while (board.pending() != 0 && settle_cycles < 20 * WORST_CYCLES) begin
         @(posedge clock);
         settle_cycles++;
      end
      repeat (WORST_CYCLES) @(posedge clock);
      if (board.pending() != 0)
         board.report_mismatch($sformatf("%0d responses never arrived", board.pending()));

      $display("Run covered %0d inserts, %0d deletes, %0d checks and %0d unused-opcode requests.",
               board.op_seen[akm_pkg::OP_INSERT], board.op_seen[akm_pkg::OP_DELETE],
               board.op_seen[akm_pkg::OP_CHECK], board.op_seen[OP_UNUSED]);
      $display("Outcomes: %0d done, %0d duplicate, %0d full, %0d not found; %s",
               board.status_seen[akm_pkg::ST_DONE], board.status_seen[akm_pkg::ST_DUP],
               board.status_seen[akm_pkg::ST_FULL], board.status_seen[akm_pkg::ST_MISSING],
               $sformatf("set emptied %0d times, alarm fired %0d time(s).",
                         board.empties, board.fires));
      if (board.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      #(TIMEOUT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
